@@ rtl/assert_macros.svh @@
// assertion macros for the velocity hold block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, clocked on clk_i and off while rst_ni is low
`define DAPVH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// concurrent check that also holds during reset
`define DAPVH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/dapvh_pkg.sv @@
// shared types and constants of the dual axis pi velocity hold
package dapvh_pkg;

  localparam int CMD_LIMIT = 1500;

  localparam logic signed [11:0] CMD_MAX = 12'(CMD_LIMIT);
  localparam logic signed [11:0] CMD_MIN = -12'(CMD_LIMIT);

  localparam logic [15:0] P_GAIN_RST = 16'd500;
  localparam logic [15:0] I_GAIN_RST = 16'd10;

  typedef enum logic [2:0] {
    REG_FLOW_MODE    = 3'd0,
    REG_TARGET_VEL_X = 3'd1,
    REG_TARGET_VEL_Y = 3'd2,
    REG_ROLL_P_GAIN  = 3'd3,
    REG_ROLL_I_GAIN  = 3'd4,
    REG_PITCH_P_GAIN = 3'd5,
    REG_PITCH_I_GAIN = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic               flow_mode;
    logic signed [15:0] target_vel_x;
    logic signed [15:0] target_vel_y;
    logic [15:0]        roll_p_gain;
    logic [15:0]        roll_i_gain;
    logic [15:0]        pitch_p_gain;
    logic [15:0]        pitch_i_gain;
  } cfg_t;

  typedef struct packed {
    logic               req_type;
    logic               module_active;
    logic               flow_valid;
    logic signed [15:0] flow_vel_x;
    logic signed [15:0] flow_vel_y;
    logic signed [15:0] body_vel_x;
    logic signed [15:0] body_vel_y;
    logic signed [15:0] heading_now;
  } in_item_t;

  typedef struct packed {
    logic               step;
    logic               clear;
    logic signed [32:0] p_x;
    logic signed [32:0] i_x;
    logic signed [32:0] p_y;
    logic signed [32:0] i_y;
    logic signed [15:0] heading;
  } prod_t;

endpackage

@@ rtl/dapvh_prod.sv @@
// error selection and gain products, registered
module dapvh_prod (
  input  logic              clk_i,
  input  logic              load_i,
  input  dapvh_pkg::cfg_t   cfg_i,
  input  dapvh_pkg::in_item_t item_i,
  output dapvh_pkg::prod_t  prod_o
);

  logic signed [16:0] err_x;
  logic signed [16:0] err_y;
  logic signed [33:0] px_full, ix_full, py_full, iy_full;
  dapvh_pkg::prod_t   prod_d, prod_q;

  always_comb begin
    if (cfg_i.flow_mode) begin
      if (item_i.flow_valid) begin
        err_x = 17'(item_i.flow_vel_x) - 17'(cfg_i.target_vel_x);
        err_y = 17'(item_i.flow_vel_y) - 17'(cfg_i.target_vel_y);
      end else begin
        err_x = '0;
        err_y = '0;
      end
    end else begin
      err_x = 17'(item_i.body_vel_x);
      err_y = 17'(item_i.body_vel_y);
    end
  end

  assign px_full = $signed({1'b0, cfg_i.pitch_p_gain}) * err_x;
  assign ix_full = $signed({1'b0, cfg_i.pitch_i_gain}) * err_x;
  assign py_full = $signed({1'b0, cfg_i.roll_p_gain}) * err_y;
  assign iy_full = $signed({1'b0, cfg_i.roll_i_gain}) * err_y;

  always_comb begin
    prod_d.step    = !item_i.req_type && item_i.module_active;
    prod_d.clear   = item_i.req_type;
    prod_d.p_x     = px_full[32:0];
    prod_d.i_x     = ix_full[32:0];
    prod_d.p_y     = py_full[32:0];
    prod_d.i_y     = iy_full[32:0];
    prod_d.heading = item_i.heading_now;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

@@ rtl/dapvh_axis.sv @@
// one axis: saturating integrator with clamp hold, scaling and command clamp
module dapvh_axis (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               upd_i,
  input  logic               clr_i,
  input  logic               negate_i,
  input  logic signed [32:0] p_term_i,
  input  logic signed [32:0] i_term_i,
  output logic signed [11:0] cmd_o,
  output logic               hit_o
);

  localparam logic signed [47:0] IntegMax = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] IntegMin = {1'b1, {47{1'b0}}};
  localparam logic signed [41:0] LimPos   = 42'(dapvh_pkg::CMD_LIMIT);
  localparam logic signed [41:0] LimNeg   = -42'(dapvh_pkg::CMD_LIMIT);

  logic signed [47:0] integ_q, integ_d, integ_next;
  logic               hold_q, hold_d;
  logic signed [32:0] delta;
  logic signed [48:0] acc;
  logic signed [48:0] sum;
  logic signed [49:0] val;
  logic signed [41:0] quo;
  logic signed [41:0] clamped;

  assign delta = hold_q ? '0 : i_term_i;
  assign acc   = {integ_q[47], integ_q} + {{16{delta[32]}}, delta};

  always_comb begin
    if (acc[48] != acc[47]) begin
      integ_next = acc[48] ? IntegMin : IntegMax;
    end else begin
      integ_next = acc[47:0];
    end
  end

  assign sum = {integ_next[47], integ_next} + {{16{p_term_i[32]}}, p_term_i};
  assign val = negate_i ? -{sum[48], sum} : {sum[48], sum};
  // divide by 256 rounding toward zero
  assign quo = val[49:8] + 42'(val[49] && (val[7:0] != 8'd0));

  always_comb begin
    if (quo > LimPos) begin
      clamped = LimPos;
      hit_o   = 1'b1;
    end else if (quo < LimNeg) begin
      clamped = LimNeg;
      hit_o   = 1'b1;
    end else begin
      clamped = quo;
      hit_o   = 1'b0;
    end
  end

  assign cmd_o = clamped[11:0];

  always_comb begin
    integ_d = integ_q;
    hold_d  = hold_q;
    if (clr_i) begin
      integ_d = '0;
    end else if (upd_i) begin
      integ_d = integ_next;
      hold_d  = hit_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      hold_q  <= 1'b0;
    end else begin
      integ_q <= integ_d;
      hold_q  <= hold_d;
    end
  end

endmodule

@@ rtl/dual_axis_pi_velocity_hold_top.sv @@
// top level of the dual axis pi velocity hold
// Two PI velocity loops, x to pitch and y to roll, with clamping anti-windup.
// An input transfer passes an input register, a gain product register and
// then the axis integrators into the result register. One item is taken
// every cycle when the result side keeps up; the product multipliers and the
// integrator add and clamp each sit in one register stage. Mode entry items
// clear both integrators and inactive steps give no result. Configuration
// writes are taken at any time but must only be made while the block is idle.
`include "assert_macros.svh"

module dual_axis_pi_velocity_hold_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic               module_active_i,
  input  logic               flow_valid_i,
  input  logic signed [15:0] flow_vel_x_i,
  input  logic signed [15:0] flow_vel_y_i,
  input  logic signed [15:0] body_vel_x_i,
  input  logic signed [15:0] body_vel_y_i,
  input  logic signed [15:0] heading_now_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [11:0] roll_cmd_o,
  output logic signed [11:0] pitch_cmd_o,
  output logic signed [15:0] heading_cmd_o,
  output logic               roll_clamped_o,
  output logic               pitch_clamped_o
);

  dapvh_pkg::cfg_t     cfg_q, cfg_d;
  dapvh_pkg::in_item_t in_item_q;
  dapvh_pkg::prod_t    prod;

  logic in_vld_q, in_vld_d;
  logic prod_vld_q, prod_vld_d;
  logic out_vld_q, out_vld_d;
  logic out_space, prod_go, prod_space, in_go, in_take;
  logic step_go, clear_go;

  logic signed [11:0] roll_cmd, pitch_cmd;
  logic               roll_hit, pitch_hit;
  logic               heading_pending_q, heading_pending_d;
  logic signed [15:0] heading_hold_q, heading_hold_d;
  logic signed [15:0] heading_cmd;

  logic signed [11:0] roll_cmd_q, pitch_cmd_q;
  logic signed [15:0] heading_cmd_q;
  logic               roll_clamped_q, pitch_clamped_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dapvh_pkg::REG_FLOW_MODE:    cfg_d.flow_mode    = cfg_data_i[0];
        dapvh_pkg::REG_TARGET_VEL_X: cfg_d.target_vel_x = $signed(cfg_data_i);
        dapvh_pkg::REG_TARGET_VEL_Y: cfg_d.target_vel_y = $signed(cfg_data_i);
        dapvh_pkg::REG_ROLL_P_GAIN:  cfg_d.roll_p_gain  = cfg_data_i;
        dapvh_pkg::REG_ROLL_I_GAIN:  cfg_d.roll_i_gain  = cfg_data_i;
        dapvh_pkg::REG_PITCH_P_GAIN: cfg_d.pitch_p_gain = cfg_data_i;
        dapvh_pkg::REG_PITCH_I_GAIN: cfg_d.pitch_i_gain = cfg_data_i;
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flow_mode    <= 1'b1;
      cfg_q.target_vel_x <= '0;
      cfg_q.target_vel_y <= '0;
      cfg_q.roll_p_gain  <= dapvh_pkg::P_GAIN_RST;
      cfg_q.roll_i_gain  <= dapvh_pkg::I_GAIN_RST;
      cfg_q.pitch_p_gain <= dapvh_pkg::P_GAIN_RST;
      cfg_q.pitch_i_gain <= dapvh_pkg::I_GAIN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // pipeline flow control
  assign out_space  = !out_vld_q || out_ready_i;
  assign prod_go    = prod_vld_q && out_space;
  assign prod_space = !prod_vld_q || prod_go;
  assign in_go      = in_vld_q && prod_space;
  assign in_ready_o = !in_vld_q || prod_space;
  assign in_take    = in_valid_i && in_ready_o;

  assign step_go  = prod_go && prod.step;
  assign clear_go = prod_go && prod.clear;

  always_comb begin
    in_vld_d   = in_take ? 1'b1 : (in_go ? 1'b0 : in_vld_q);
    prod_vld_d = in_go ? 1'b1 : (prod_go ? 1'b0 : prod_vld_q);
    out_vld_d  = step_go ? 1'b1 : ((out_vld_q && out_ready_i) ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      in_vld_q   <= in_vld_d;
      prod_vld_q <= prod_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.req_type      <= req_type_i;
      in_item_q.module_active <= module_active_i;
      in_item_q.flow_valid    <= flow_valid_i;
      in_item_q.flow_vel_x    <= flow_vel_x_i;
      in_item_q.flow_vel_y    <= flow_vel_y_i;
      in_item_q.body_vel_x    <= body_vel_x_i;
      in_item_q.body_vel_y    <= body_vel_y_i;
      in_item_q.heading_now   <= heading_now_i;
    end
  end

  dapvh_prod u_prod (
    .clk_i  (clk_i),
    .load_i (in_go),
    .cfg_i  (cfg_q),
    .item_i (in_item_q),
    .prod_o (prod)
  );

  dapvh_axis u_axis_pitch (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (step_go),
    .clr_i    (clear_go),
    .negate_i (1'b0),
    .p_term_i (prod.p_x),
    .i_term_i (prod.i_x),
    .cmd_o    (pitch_cmd),
    .hit_o    (pitch_hit)
  );

  dapvh_axis u_axis_roll (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (step_go),
    .clr_i    (clear_go),
    .negate_i (1'b1),
    .p_term_i (prod.p_y),
    .i_term_i (prod.i_y),
    .cmd_o    (roll_cmd),
    .hit_o    (roll_hit)
  );

  // heading latch on the first executed step
  assign heading_cmd = heading_pending_q ? prod.heading : heading_hold_q;

  always_comb begin
    heading_pending_d = heading_pending_q;
    heading_hold_d    = heading_hold_q;
    if (step_go) begin
      heading_pending_d = 1'b0;
      heading_hold_d    = heading_cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_pending_q <= 1'b1;
      heading_hold_q    <= '0;
    end else begin
      heading_pending_q <= heading_pending_d;
      heading_hold_q    <= heading_hold_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (step_go) begin
      roll_cmd_q      <= roll_cmd;
      pitch_cmd_q     <= pitch_cmd;
      heading_cmd_q   <= heading_cmd;
      roll_clamped_q  <= roll_hit;
      pitch_clamped_q <= pitch_hit;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign roll_cmd_o      = roll_cmd_q;
  assign pitch_cmd_o     = pitch_cmd_q;
  assign heading_cmd_o   = heading_cmd_q;
  assign roll_clamped_o  = roll_clamped_q;
  assign pitch_clamped_o = pitch_clamped_q;

  // checks
  `DAPVH_ASSERT(a_roll_in_range,
                out_vld_q |-> (roll_cmd_q <= dapvh_pkg::CMD_MAX &&
                               roll_cmd_q >= dapvh_pkg::CMD_MIN),
                "roll command out of range")
  `DAPVH_ASSERT(a_roll_hit_at_limit,
                (out_vld_q && roll_clamped_q) |-> (roll_cmd_q == dapvh_pkg::CMD_MAX ||
                                                   roll_cmd_q == dapvh_pkg::CMD_MIN),
                "roll clamp flag without limit value")
  `DAPVH_ASSERT(a_pitch_hit_at_limit,
                (out_vld_q && pitch_clamped_q) |-> (pitch_cmd_q == dapvh_pkg::CMD_MAX ||
                                                    pitch_cmd_q == dapvh_pkg::CMD_MIN),
                "pitch clamp flag without limit value")
  `DAPVH_ASSERT(a_heading_latch_on_step,
                $fell(heading_pending_q) |-> ($past(step_go) && out_vld_q),
                "heading latched without a step")
  `DAPVH_ASSERT_ALWAYS(a_no_result_without_item,
                       (!rst_ni) |=> (!out_vld_q || $past(rst_ni)),
                       "result valid out of reset")

endmodule
